[src/uid_filter_policy_table_macros.svh]
// ---------------------------------------------------------------------------
// uid_filter_policy_table_macros.svh
// Assertion shorthands used by the checker file.
// ---------------------------------------------------------------------------
`ifndef UID_FILTER_POLICY_TABLE_MACROS_SVH
`define UID_FILTER_POLICY_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define UFPT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufpt check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define UFPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufpt check failed");

`endif

[src/ufpt_pkg.sv]
// ---------------------------------------------------------------------------
// ufpt_pkg
// Shared constants, codes and types of the user-ID filter policy table.
// ---------------------------------------------------------------------------
`default_nettype none

package ufpt_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 32;

    localparam logic [ID_W-1:0] APP_ID_BASE = 32'd10000;

    // Operation codes
    localparam logic [1:0] OP_QUERY  = 2'd0;
    localparam logic [1:0] OP_ADD    = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_CLEAR  = 2'd3;

    // Status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ZERO   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_ABSENT = 2'd3;

    // Register indexes
    localparam int          PADDR_W           = 4;
    localparam logic [1:0]  REG_FILTER_ENABLE = 2'd0;
    localparam logic [1:0]  REG_UID_LIST_MODE = 2'd1;
    localparam logic [1:0]  REG_FILTER_SYS    = 2'd2;
    localparam logic [1:0]  REG_MANAGER_ID    = 2'd3;

    typedef struct packed {
        logic            filter_enable;
        logic            uid_list_mode;
        logic            filter_system_ids;
        logic [ID_W-1:0] manager_id;
    } cfg_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [ID_W-1:0]  wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } ram_req_t;

endpackage

`default_nettype wire

[src/ufpt_ram.sv]
// ---------------------------------------------------------------------------
// ufpt_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module ufpt_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 8
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [DATA_W-1:0] wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [(1 << ADDR_W)];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[src/ufpt_regs.sv]
// ---------------------------------------------------------------------------
// ufpt_regs
// APB configuration registers of the filter policy table.
// ---------------------------------------------------------------------------
`default_nettype none

module ufpt_regs (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [ufpt_pkg::PADDR_W-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic      [31:0]                 prdata,
    output logic                             pready,
    output ufpt_pkg::cfg_t                   cfg
);

    ufpt_pkg::cfg_t cfg_reg;
    ufpt_pkg::cfg_t cfg_next;
    logic [1:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[ufpt_pkg::PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                ufpt_pkg::REG_FILTER_ENABLE: cfg_next.filter_enable     = pwdata[0];
                ufpt_pkg::REG_UID_LIST_MODE: cfg_next.uid_list_mode     = pwdata[0];
                ufpt_pkg::REG_FILTER_SYS:    cfg_next.filter_system_ids = pwdata[0];
                ufpt_pkg::REG_MANAGER_ID:    cfg_next.manager_id        = pwdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            ufpt_pkg::REG_FILTER_ENABLE: prdata = {31'd0, cfg_reg.filter_enable};
            ufpt_pkg::REG_UID_LIST_MODE: prdata = {31'd0, cfg_reg.uid_list_mode};
            ufpt_pkg::REG_FILTER_SYS:    prdata = {31'd0, cfg_reg.filter_system_ids};
            ufpt_pkg::REG_MANAGER_ID:    prdata = cfg_reg.manager_id;
            default:                     prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[src/ufpt_ctrl.sv]
// ---------------------------------------------------------------------------
// ufpt_ctrl
// Request sequencer: scans the ID table, updates it and the count, and
// holds the result in an output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ufpt_ctrl (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire ufpt_pkg::cfg_t               cfg,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [1:0]                   opcode,
    input  wire logic [ufpt_pkg::ID_W-1:0]    user_id,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic      [1:0]                   status,
    output logic                              filter,
    output logic      [ufpt_pkg::CNT_W-1:0]   count_after,
    output ufpt_pkg::ram_req_t                ram_req,
    input  wire logic [ufpt_pkg::ID_W-1:0]    ram_rdata
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_RDLAST = 3'd2;
    localparam logic [2:0] S_MOVE   = 3'd3;
    localparam logic [2:0] S_DONE   = 3'd4;

    localparam logic [ufpt_pkg::CNT_W-1:0] DEPTH_CNT =
        ufpt_pkg::CNT_W'(ufpt_pkg::TABLE_DEPTH);

    logic [2:0]                   state_reg, state_next;
    logic [1:0]                   op_reg, op_next;
    logic [ufpt_pkg::ID_W-1:0]    id_reg, id_next;
    logic [ufpt_pkg::CNT_W-1:0]   count_reg, count_next;
    logic [ufpt_pkg::CNT_W-1:0]   addr_reg, addr_next;
    logic                         cmp_valid_reg, cmp_valid_next;
    logic [ufpt_pkg::IDX_W-1:0]   cmp_idx_reg, cmp_idx_next;
    logic [ufpt_pkg::IDX_W-1:0]   slot_reg, slot_next;
    logic [1:0]                   res_status_reg, res_status_next;
    logic                         res_filter_reg, res_filter_next;
    logic                         out_valid_reg, out_valid_next;
    logic [1:0]                   out_status_reg, out_status_next;
    logic                         out_filter_reg, out_filter_next;
    logic [ufpt_pkg::CNT_W-1:0]   out_count_reg, out_count_next;

    logic accept;
    logic hit;
    logic rd_more;
    logic mgr_hit;
    logic [ufpt_pkg::CNT_W-1:0] last_idx;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign hit      = cmp_valid_reg && (ram_rdata == id_reg);
    assign rd_more  = (addr_reg < count_reg);
    assign mgr_hit  = (user_id == cfg.manager_id);
    assign last_idx = count_reg - ufpt_pkg::CNT_W'(1);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        count_next      = count_reg;
        addr_next       = addr_reg;
        cmp_valid_next  = 1'b0;
        cmp_idx_next    = cmp_idx_reg;
        slot_next       = slot_reg;
        res_status_next = res_status_reg;
        res_filter_next = res_filter_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_status_next = out_status_reg;
        out_filter_next = out_filter_reg;
        out_count_next  = out_count_reg;
        ram_req         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next         = opcode;
                    id_next         = user_id;
                    addr_next       = '0;
                    res_status_next = ufpt_pkg::ST_OK;
                    res_filter_next = 1'b0;
                    state_next      = S_DONE;
                    unique case (opcode) inside
                        ufpt_pkg::OP_QUERY:
                        begin
                            if (cfg.filter_enable && !mgr_hit)
                            begin
                                if (!cfg.uid_list_mode)
                                begin
                                    res_filter_next = (user_id >= ufpt_pkg::APP_ID_BASE)
                                                      || cfg.filter_system_ids;
                                end
                                else if (user_id == '0)
                                begin
                                    res_filter_next = cfg.filter_system_ids;
                                end
                                else
                                begin
                                    state_next = S_SCAN;
                                end
                            end
                        end
                        ufpt_pkg::OP_ADD, ufpt_pkg::OP_REMOVE:
                        begin
                            if (user_id == '0)
                            begin
                                res_status_next = ufpt_pkg::ST_ZERO;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        ufpt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                // Issue the next read while comparing the data of the last one.
                ram_req.re     = rd_more;
                ram_req.raddr  = addr_reg[ufpt_pkg::IDX_W-1:0];
                cmp_valid_next = rd_more;
                cmp_idx_next   = addr_reg[ufpt_pkg::IDX_W-1:0];
                addr_next      = addr_reg + ufpt_pkg::CNT_W'(rd_more);
                if (hit)
                begin
                    cmp_valid_next = 1'b0;
                    slot_next      = cmp_idx_reg;
                    state_next     = S_DONE;
                    case (op_reg)
                        ufpt_pkg::OP_QUERY:  res_filter_next = 1'b1;
                        ufpt_pkg::OP_REMOVE: state_next      = S_RDLAST;
                        default:             res_status_next = ufpt_pkg::ST_OK;
                    endcase
                end
                else if (!rd_more && !cmp_valid_reg)
                begin
                    state_next = S_DONE;
                    case (op_reg)
                        ufpt_pkg::OP_ADD:
                        begin
                            if (count_reg >= DEPTH_CNT)
                            begin
                                res_status_next = ufpt_pkg::ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = count_reg[ufpt_pkg::IDX_W-1:0];
                                ram_req.wdata = id_reg;
                                count_next    = count_reg + ufpt_pkg::CNT_W'(1);
                            end
                        end
                        ufpt_pkg::OP_REMOVE: res_status_next = ufpt_pkg::ST_ABSENT;
                        default:             res_filter_next = 1'b0;
                    endcase
                end
            end

            S_RDLAST:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = last_idx[ufpt_pkg::IDX_W-1:0];
                state_next    = S_MOVE;
            end

            S_MOVE:
            begin
                // Move the last entry into the freed slot.
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_reg;
                ram_req.wdata = ram_rdata;
                count_next    = last_idx;
                state_next    = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_filter_next = res_filter_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cmp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cmp_valid_reg <= cmp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        addr_reg       <= addr_next;
        cmp_idx_reg    <= cmp_idx_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_filter_reg <= res_filter_next;
        out_status_reg <= out_status_next;
        out_filter_reg <= out_filter_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign filter      = out_filter_reg;
    assign count_after = out_count_reg;

endmodule

`default_nettype wire

[src/uid_filter_policy_table.sv]
// Throughput: one request at a time; a table scan (list-mode query, add,
//   remove) reads the ID table one entry per cycle through its single
//   read port, and a stalled result holds the next request back.
// Reset: rst_n clears configuration, entry count and handshake state; table
//   contents are not cleared, only entries below the count are ever read.
// ---------------------------------------------------------------------------
// uid_filter_policy_table
// User-ID filter policy table: query, add, remove and clear against a
// 256-entry ID set held in one synchronous RAM.
// ---------------------------------------------------------------------------
`default_nettype none

module uid_filter_policy_table (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // request channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [1:0]                    opcode,
    input  wire logic [31:0]                   user_id,
    // result channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic      [1:0]                    status,
    output logic                               filter,
    output logic      [8:0]                    count_after,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ufpt_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready
);

    ufpt_pkg::cfg_t     cfg;
    ufpt_pkg::ram_req_t ram_req;
    logic [ufpt_pkg::ID_W-1:0] ram_rdata;

    // Config regs; user writes only with no request in flight (not enforced).
    ufpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Sequencer: accepts a request when idle, scans the table through the
    // RAM read port (one entry per cycle, each compare in the cycle after its
    // read), performs the add or swap-remove write, then loads the result
    // register. A new request can be taken while that loaded result waits.
    ufpt_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .user_id     (user_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .filter      (filter),
        .count_after (count_after),
        .ram_req     (ram_req),
        .ram_rdata   (ram_rdata)
    );

    // ID table storage. Writes and reads of one entry never fall in the
    // same cycle, so no forwarding is needed.
    ufpt_ram #(
        .DATA_W (ufpt_pkg::ID_W),
        .ADDR_W (ufpt_pkg::IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

endmodule

`default_nettype wire

[src/ufpt_checker.sv]
// ---------------------------------------------------------------------------
// ufpt_checker
// Port-level checks of the filter policy table, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "uid_filter_policy_table_macros.svh"

module ufpt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          in_valid,
    input wire logic                          in_stall,
    input wire logic                          out_valid,
    input wire logic                          out_stall,
    input wire logic [1:0]                    status,
    input wire logic                          filter,
    input wire logic [8:0]                    count_after
);

    logic in_acc;
    assign in_acc = in_valid && !in_stall;

    // Hold a stalled result.
    `UFPT_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
        out_valid && $stable(status) && $stable(filter) && $stable(count_after))

    // Count never exceeds the table depth.
    `UFPT_ASSERT_NOW(a_count_range, out_valid,
        count_after <= 9'(ufpt_pkg::TABLE_DEPTH))

    // A filter decision comes only with an ok status.
    `UFPT_ASSERT_NOW(a_filter_ok, out_valid && filter, status == ufpt_pkg::ST_OK)

    // Busy right after taking a request.
    `UFPT_ASSERT_NEXT(a_busy_after_acc, in_acc, in_stall)

endmodule

bind uid_filter_policy_table ufpt_checker u_ufpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .filter      (filter),
    .count_after (count_after)
);

`default_nettype wire
